FILE: hw/rtl/tpf_pkg.sv
// Shared types, constants and a helper function for the tone phase line fit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tpf_pkg;

  localparam int MAX_TONES_DEF    = 4;
  localparam int MAX_CHANNELS_DEF = 4096;
  localparam int NUM_TONE_WORDS   = 4;
  localparam int TONE_WORD_W      = 44;
  localparam int FREQ_W           = 32;
  localparam int CH_W             = 12;
  localparam int CC_W             = 13;
  localparam int PHASE_W          = 32;
  localparam int OUT_W            = 48;
  localparam int CNT_W            = 32;
  localparam int WIDE_W           = 128;
  localparam int LIMB_W           = 32;
  localparam int NUM_LIMBS        = WIDE_W / LIMB_W;
  localparam int FRAC_SHIFT       = 16;
  localparam int ADDR_W           = 6;
  localparam int DATA_W           = 64;
  localparam int TC_W             = 3;
  localparam int S_TDATA_W        = 64;
  localparam int M_TDATA_W        = 160;

  localparam logic [LIMB_W-1:0] INV_TWO_PI_Q32 = 32'd683565276;

  typedef enum logic [2:0] {
    REG_BYPASS,
    REG_TONE_COUNT,
    REG_TONE_0,
    REG_TONE_1,
    REG_TONE_2,
    REG_TONE_3
  } reg_idx_t;

  typedef enum logic [2:0] {
    MS_DFDP,
    MS_DFDF,
    MS_NUMK,
    MS_DENSP,
    MS_NUMSF,
    MS_DENN
  } mul_sel_t;

  typedef enum logic {
    DS_TAU,
    DS_THETA
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     init;
    logic     count_good;
    logic     count_bad;
    logic     sum;
    logic     fail;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     div_go;
    div_sel_t div_sel;
  } tpf_cmd_t;

  typedef struct packed {
    logic ok;
    logic den_zero;
    logic mul_done;
    logic div_done;
  } tpf_status_t;

  function automatic logic [TC_W-1:0] active_tones(input logic [TC_W-1:0] tc,
                                                   input int max_tones);
    logic [TC_W-1:0] n;
    n = tc;
    if (n < TC_W'(2)) n = TC_W'(2);
    if (n > TC_W'(max_tones)) n = TC_W'(max_tones);
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tone_phase_line_fit.sv
// Top level of the tone phase line fit: configuration registers and the two units.
// Instantiates tpf_ctrl and tpf_dp; uses tpf_pkg.
//
//   Port group   Direction  Carries
//   s_*          in         one channel sample per request, tlast closes the frame
//   m_*          out        one fit result per frame
//   APB          in/out     bypass, tone count and four tone words
//
// Samples are taken one per cycle while no fit is running.
// After the last sample of a frame the fit runs on the 128-step divider, used twice,
// and on the ten-step shared multiplier.
// A bypassed or flagged frame returns its result on the next cycle.
// No sample is taken from the last sample until the result request has been taken.
// Reset is synchronous; it clears the captured phases, the fit and both counters.
`timescale 1ns / 1ps
`default_nettype none

module tone_phase_line_fit #(
  parameter int MAX_TONES    = tpf_pkg::MAX_TONES_DEF,
  parameter int MAX_CHANNELS = tpf_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // channel_count[12:0], channel[24:13], phase[56:25], zero fill above
  input  wire logic [tpf_pkg::S_TDATA_W-1:0]  s_tdata,
  // frame_error[0]
  input  wire logic                           s_tuser,
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // tau[47:0], theta[95:48], good_frames[127:96], bad_frames[159:128]
  output logic [tpf_pkg::M_TDATA_W-1:0]       m_tdata,
  // fit_valid[0]
  output logic                                m_tuser,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tpf_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tpf_pkg::DATA_W-1:0]     pwdata,
  output logic [tpf_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  logic                             bypass;
  logic [tpf_pkg::TC_W-1:0]         tone_count;
  logic [tpf_pkg::NUM_TONE_WORDS-1:0][tpf_pkg::TONE_WORD_W-1:0] tone_words;
  logic [tpf_pkg::TC_W-1:0]         n;
  logic [$clog2(MAX_TONES)-1:0]     idx;
  tpf_pkg::tpf_cmd_t                cmd;
  tpf_pkg::tpf_status_t             status;
  tpf_pkg::reg_idx_t                reg_sel;
  logic                             wr_en;
  logic [tpf_pkg::OUT_W-1:0]        tau;
  logic [tpf_pkg::OUT_W-1:0]        theta;
  logic                             fit_valid;
  logic [tpf_pkg::CNT_W-1:0]        good_frames;
  logic [tpf_pkg::CNT_W-1:0]        bad_frames;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = tpf_pkg::reg_idx_t'(paddr[tpf_pkg::ADDR_W-1:3]);
  assign n       = tpf_pkg::active_tones(tone_count, MAX_TONES);

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass     <= 1'b0;
      tone_count <= tpf_pkg::TC_W'(2);
      tone_words <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        tpf_pkg::REG_BYPASS:     bypass <= pwdata[0];
        tpf_pkg::REG_TONE_COUNT: tone_count <= pwdata[tpf_pkg::TC_W-1:0];
        tpf_pkg::REG_TONE_0:     tone_words[0] <= pwdata[tpf_pkg::TONE_WORD_W-1:0];
        tpf_pkg::REG_TONE_1:     tone_words[1] <= pwdata[tpf_pkg::TONE_WORD_W-1:0];
        tpf_pkg::REG_TONE_2:     tone_words[2] <= pwdata[tpf_pkg::TONE_WORD_W-1:0];
        tpf_pkg::REG_TONE_3:     tone_words[3] <= pwdata[tpf_pkg::TONE_WORD_W-1:0];
        default:                 bypass <= bypass;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tpf_pkg::REG_BYPASS:     prdata = tpf_pkg::DATA_W'(bypass);
      tpf_pkg::REG_TONE_COUNT: prdata = tpf_pkg::DATA_W'(tone_count);
      tpf_pkg::REG_TONE_0:     prdata = tpf_pkg::DATA_W'(tone_words[0]);
      tpf_pkg::REG_TONE_1:     prdata = tpf_pkg::DATA_W'(tone_words[1]);
      tpf_pkg::REG_TONE_2:     prdata = tpf_pkg::DATA_W'(tone_words[2]);
      tpf_pkg::REG_TONE_3:     prdata = tpf_pkg::DATA_W'(tone_words[3]);
      default:                 prdata = '0;
    endcase
  end

  tpf_ctrl #(
    .MAX_TONES (MAX_TONES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tlast     (s_tlast),
    .frame_error (s_tuser),
    .bypass      (bypass),
    .n           (n),
    .m_tready    (m_tready),
    .status      (status),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .idx         (idx),
    .cmd         (cmd)
  );

  tpf_dp #(
    .MAX_TONES    (MAX_TONES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .idx           (idx),
    .n             (n),
    .tone_words    (tone_words),
    .channel_count (s_tdata[12:0]),
    .channel       (s_tdata[24:13]),
    .phase         (s_tdata[56:25]),
    .status        (status),
    .tau           (tau),
    .theta         (theta),
    .fit_valid     (fit_valid),
    .good_frames   (good_frames),
    .bad_frames    (bad_frames)
  );

  assign m_tdata = {bad_frames, good_frames, theta, tau};
  assign m_tuser = fit_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/tpf_mul.sv
// Multi-cycle multiplier giving a 128-bit product modulo 2^128.
// One 32 by 32 partial product per cycle; uses tpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpf_mul (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      go,
  input  wire logic [tpf_pkg::WIDE_W-1:0] a,
  input  wire logic [tpf_pkg::WIDE_W-1:0] b,
  output logic                           done,
  output logic [tpf_pkg::WIDE_W-1:0]     prod
);

  localparam int LI_W = $clog2(tpf_pkg::NUM_LIMBS);

  logic [tpf_pkg::WIDE_W-1:0]   a_r;
  logic [tpf_pkg::WIDE_W-1:0]   b_r;
  logic [tpf_pkg::WIDE_W-1:0]   acc;
  logic [LI_W-1:0]              li;
  logic [LI_W-1:0]              lj;
  logic                         busy;
  logic [2*tpf_pkg::LIMB_W-1:0] pp;
  logic [LI_W:0]                lsum;
  logic [tpf_pkg::WIDE_W-1:0]   term;
  logic                         diag;

  assign pp   = a_r[li*tpf_pkg::LIMB_W +: tpf_pkg::LIMB_W] *
                b_r[lj*tpf_pkg::LIMB_W +: tpf_pkg::LIMB_W];
  assign lsum = {1'b0, li} + {1'b0, lj};
  assign term = tpf_pkg::WIDE_W'(pp) << (tpf_pkg::LIMB_W * lsum);
  assign diag = (lsum == (LI_W+1)'(tpf_pkg::NUM_LIMBS - 1));
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !go && busy && diag && (li == LI_W'(tpf_pkg::NUM_LIMBS - 1));
      if (go) begin
        busy <= 1'b1;
        a_r  <= a;
        b_r  <= b;
        acc  <= '0;
        li   <= '0;
        lj   <= '0;
      end else if (busy) begin
        acc <= acc + term;
        if (diag) begin
          if (li == LI_W'(tpf_pkg::NUM_LIMBS - 1)) begin
            busy <= 1'b0;
          end
          li <= li + LI_W'(1);
          lj <= '0;
        end else begin
          lj <= lj + LI_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tpf_div.sv
// Restoring divider for 128-bit unsigned operands, one quotient bit per cycle.
// Uses tpf_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module tpf_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [tpf_pkg::WIDE_W-1:0] dividend,
  input  wire logic [tpf_pkg::WIDE_W-1:0] divisor,
  output logic                            done,
  output logic [tpf_pkg::WIDE_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(tpf_pkg::WIDE_W);

  logic [tpf_pkg::WIDE_W-1:0] dvd;
  logic [tpf_pkg::WIDE_W-1:0] dvs;
  logic [tpf_pkg::WIDE_W-1:0] rem;
  logic [tpf_pkg::WIDE_W-1:0] q;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [tpf_pkg::WIDE_W:0]   rem_sh;
  logic [tpf_pkg::WIDE_W:0]   rem_sub;
  logic                       fits;

  assign rem_sh   = {rem, dvd[tpf_pkg::WIDE_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !go && busy && (cnt == CNT_W'(tpf_pkg::WIDE_W - 1));
      if (go) begin
        busy <= 1'b1;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        q    <= '0;
        cnt  <= '0;
      end else if (busy) begin
        dvd <= dvd << 1;
        if (fits) begin
          rem <= rem_sub[tpf_pkg::WIDE_W-1:0];
          q   <= {q[tpf_pkg::WIDE_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[tpf_pkg::WIDE_W-1:0];
          q   <= {q[tpf_pkg::WIDE_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(tpf_pkg::WIDE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tpf_ctrl.sv
// Controller of the line fit: sample handshake, fit sequencing and result hand-off.
// Drives the datapath through tpf_pkg command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tpf_ctrl #(
  parameter int MAX_TONES = tpf_pkg::MAX_TONES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  input  wire logic                         s_tlast,
  input  wire logic                         frame_error,
  input  wire logic                         bypass,
  input  wire logic [tpf_pkg::TC_W-1:0]     n,
  input  wire logic                         m_tready,
  input  wire tpf_pkg::tpf_status_t         status,
  output logic                              s_tready,
  output logic                              m_tvalid,
  output logic [$clog2(MAX_TONES)-1:0]      idx,
  output tpf_pkg::tpf_cmd_t                 cmd
);

  localparam int IDX_W = $clog2(MAX_TONES);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_CHECK, S_NUM, S_DEN, S_ZCHK, S_TAU_M, S_TAU_D,
    S_A_M, S_B_M, S_N_M, S_TH_D, S_EMIT
  } state_t;

  state_t             state;
  logic               accept;
  logic               last_go;
  logic               idx_last;
  logic               mul_go;
  logic               mul_go_next;
  tpf_pkg::mul_sel_t  mul_sel;
  logic               div_go;
  logic               div_go_next;
  tpf_pkg::div_sel_t  div_sel;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign last_go  = accept && s_tlast && !bypass;
  assign idx_last = ((4'(idx) + 4'd1) == 4'(n));

  always_comb begin
    mul_go_next = ((state == S_CHECK) && status.ok) ||
                  ((state == S_NUM) && status.mul_done) ||
                  ((state == S_DEN) && status.mul_done && !idx_last) ||
                  ((state == S_ZCHK) && !status.den_zero) ||
                  ((state == S_TAU_D) && status.div_done) ||
                  ((state == S_A_M) && status.mul_done) ||
                  ((state == S_B_M) && status.mul_done);
    div_go_next = ((state == S_TAU_M) && status.mul_done) ||
                  ((state == S_N_M) && status.mul_done);
  end

  always_comb begin
    cmd            = '0;
    cmd.capture    = accept && !bypass;
    cmd.count_bad  = last_go && frame_error;
    cmd.count_good = last_go && !frame_error;
    cmd.init       = last_go && !frame_error;
    cmd.sum        = (state == S_SUM);
    cmd.fail       = ((state == S_CHECK) && !status.ok) ||
                     ((state == S_ZCHK) && status.den_zero);
    cmd.mul_go     = mul_go;
    cmd.mul_sel    = mul_sel;
    cmd.div_go     = div_go;
    cmd.div_sel    = div_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      mul_go   <= 1'b0;
      mul_sel  <= tpf_pkg::MS_DFDP;
      div_go   <= 1'b0;
      div_sel  <= tpf_pkg::DS_TAU;
      idx      <= '0;
    end else begin
      mul_go <= mul_go_next;
      div_go <= div_go_next;
      case (state)
        S_IDLE: begin
          if (accept && s_tlast) begin
            if (bypass || frame_error) begin
              m_tvalid <= 1'b1;
              state    <= S_EMIT;
            end else begin
              idx   <= '0;
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (idx_last) begin
            state <= S_CHECK;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_CHECK: begin
          if (!status.ok) begin
            m_tvalid <= 1'b1;
            state    <= S_EMIT;
          end else begin
            idx     <= '0;
            mul_sel <= tpf_pkg::MS_DFDP;
            state   <= S_NUM;
          end
        end
        S_NUM: begin
          if (status.mul_done) begin
            mul_sel <= tpf_pkg::MS_DFDF;
            state   <= S_DEN;
          end
        end
        S_DEN: begin
          if (status.mul_done) begin
            if (idx_last) begin
              state <= S_ZCHK;
            end else begin
              idx     <= idx + IDX_W'(1);
              mul_sel <= tpf_pkg::MS_DFDP;
              state   <= S_NUM;
            end
          end
        end
        S_ZCHK: begin
          if (status.den_zero) begin
            m_tvalid <= 1'b1;
            state    <= S_EMIT;
          end else begin
            mul_sel <= tpf_pkg::MS_NUMK;
            state   <= S_TAU_M;
          end
        end
        S_TAU_M: begin
          if (status.mul_done) begin
            div_sel <= tpf_pkg::DS_TAU;
            state   <= S_TAU_D;
          end
        end
        S_TAU_D: begin
          if (status.div_done) begin
            mul_sel <= tpf_pkg::MS_DENSP;
            state   <= S_A_M;
          end
        end
        S_A_M: begin
          if (status.mul_done) begin
            mul_sel <= tpf_pkg::MS_NUMSF;
            state   <= S_B_M;
          end
        end
        S_B_M: begin
          if (status.mul_done) begin
            mul_sel <= tpf_pkg::MS_DENN;
            state   <= S_N_M;
          end
        end
        S_N_M: begin
          if (status.mul_done) begin
            div_sel <= tpf_pkg::DS_THETA;
            state   <= S_TH_D;
          end
        end
        S_TH_D: begin
          if (status.div_done) begin
            m_tvalid <= 1'b1;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tpf_dp.sv
// Datapath of the line fit: phase capture, sums, products, quotients and counters.
// Uses tpf_pkg, tpf_mul and tpf_div; commanded by tpf_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tpf_dp #(
  parameter int MAX_TONES    = tpf_pkg::MAX_TONES_DEF,
  parameter int MAX_CHANNELS = tpf_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tpf_pkg::tpf_cmd_t             cmd,
  input  wire logic [$clog2(MAX_TONES)-1:0]  idx,
  input  wire logic [tpf_pkg::TC_W-1:0]      n,
  input  wire logic [tpf_pkg::NUM_TONE_WORDS-1:0][tpf_pkg::TONE_WORD_W-1:0] tone_words,
  input  wire logic [tpf_pkg::CC_W-1:0]      channel_count,
  input  wire logic [tpf_pkg::CH_W-1:0]      channel,
  input  wire logic [tpf_pkg::PHASE_W-1:0]   phase,
  output tpf_pkg::tpf_status_t               status,
  output logic [tpf_pkg::OUT_W-1:0]          tau,
  output logic [tpf_pkg::OUT_W-1:0]          theta,
  output logic                               fit_valid,
  output logic [tpf_pkg::CNT_W-1:0]          good_frames,
  output logic [tpf_pkg::CNT_W-1:0]          bad_frames
);

  localparam int SUM_W = tpf_pkg::PHASE_W + $clog2(MAX_TONES) + 1;
  localparam int DEV_W = SUM_W + 4;
  localparam int W     = tpf_pkg::WIDE_W;

  logic [tpf_pkg::CH_W-1:0]           tone_ch [MAX_TONES];
  logic signed [tpf_pkg::FREQ_W-1:0]  tone_f [MAX_TONES];
  logic [tpf_pkg::PHASE_W-1:0]        tone_phases [MAX_TONES];

  logic signed [SUM_W-1:0]  sf;
  logic signed [SUM_W-1:0]  sp;
  logic [tpf_pkg::CC_W-1:0] cc_reg;
  logic                     ok;
  logic [W-1:0]             num;
  logic [W-1:0]             den;
  logic [W-1:0]             tmp;
  logic [W-1:0]             dvs;
  logic                     div_neg;

  logic signed [tpf_pkg::FREQ_W-1:0]  f_sel;
  logic signed [tpf_pkg::PHASE_W-1:0] p_sel;
  logic signed [DEV_W-1:0]            n_s;
  logic signed [DEV_W-1:0]            df;
  logic signed [DEV_W-1:0]            dph;
  logic [tpf_pkg::CC_W-1:0]           ch_ext;
  logic                               ch_bad;

  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic [W-1:0] mul_p;
  logic         mul_done;
  logic [W-1:0] div_q;
  logic         div_done;
  logic [W-1:0] divisor;
  logic [W-1:0] mag;
  logic [W-1:0] dividend;
  logic [W-1:0] limit;
  logic [tpf_pkg::OUT_W-1:0] q_sat;
  logic [tpf_pkg::OUT_W-1:0] res;

  for (genvar g = 0; g < MAX_TONES; g++) begin : g_tone
    if (g < tpf_pkg::NUM_TONE_WORDS) begin : g_word
      assign tone_ch[g] = tone_words[g][tpf_pkg::TONE_WORD_W-1:tpf_pkg::FREQ_W];
      assign tone_f[g]  = signed'(tone_words[g][tpf_pkg::FREQ_W-1:0]);
    end else begin : g_zero
      assign tone_ch[g] = '0;
      assign tone_f[g]  = '0;
    end
  end

  assign f_sel  = tone_f[idx];
  assign p_sel  = signed'(tone_phases[idx]);
  assign n_s    = signed'(DEV_W'(n));
  assign df     = n_s * DEV_W'(f_sel) - DEV_W'(sf);
  assign dph    = n_s * DEV_W'(p_sel) - DEV_W'(sp);
  assign ch_ext = {1'b0, tone_ch[idx]};
  assign ch_bad = (ch_ext >= cc_reg) || (ch_ext >= tpf_pkg::CC_W'(MAX_CHANNELS));

  always_comb begin
    case (cmd.mul_sel)
      tpf_pkg::MS_DFDP: begin
        mul_a = W'(df);
        mul_b = W'(dph);
      end
      tpf_pkg::MS_DFDF: begin
        mul_a = W'(df);
        mul_b = W'(df);
      end
      tpf_pkg::MS_NUMK: begin
        mul_a = num;
        mul_b = W'(tpf_pkg::INV_TWO_PI_Q32);
      end
      tpf_pkg::MS_DENSP: begin
        mul_a = den;
        mul_b = W'(sp);
      end
      tpf_pkg::MS_NUMSF: begin
        mul_a = num;
        mul_b = W'(sf);
      end
      tpf_pkg::MS_DENN: begin
        mul_a = den;
        mul_b = W'(n);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign divisor  = (cmd.div_sel == tpf_pkg::DS_TAU) ? den : dvs;
  assign mag      = tmp[W-1] ? (W'(0) - tmp) : tmp;
  assign dividend = (mag << tpf_pkg::FRAC_SHIFT) + (divisor >> 1);
  assign limit    = div_neg ? (W'(1) << (tpf_pkg::OUT_W - 1))
                            : ((W'(1) << (tpf_pkg::OUT_W - 1)) - W'(1));
  assign q_sat    = (div_q > limit) ? limit[tpf_pkg::OUT_W-1:0]
                                    : div_q[tpf_pkg::OUT_W-1:0];
  assign res      = div_neg ? (tpf_pkg::OUT_W'(0) - q_sat) : q_sat;

  tpf_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_p)
  );

  tpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign status.ok       = ok;
  assign status.den_zero = (den == '0);
  assign status.mul_done = mul_done;
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TONES; i++) begin
        tone_phases[i] <= '0;
      end
      tau         <= '0;
      theta       <= '0;
      fit_valid   <= 1'b0;
      good_frames <= '0;
      bad_frames  <= '0;
    end else begin
      if (cmd.capture) begin
        for (int i = 0; i < MAX_TONES; i++) begin
          if (tone_ch[i] == channel) begin
            tone_phases[i] <= phase;
          end
        end
      end
      if (cmd.count_good) begin
        good_frames <= good_frames + tpf_pkg::CNT_W'(1);
      end
      if (cmd.count_bad) begin
        bad_frames <= bad_frames + tpf_pkg::CNT_W'(1);
      end
      if (cmd.fail) begin
        tau       <= '0;
        theta     <= '0;
        fit_valid <= 1'b0;
      end
      if (div_done) begin
        if (cmd.div_sel == tpf_pkg::DS_TAU) begin
          tau <= res;
        end else begin
          theta     <= res;
          fit_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      sf     <= '0;
      sp     <= '0;
      num    <= '0;
      den    <= '0;
      ok     <= 1'b1;
      cc_reg <= channel_count;
    end
    if (cmd.sum) begin
      sf <= sf + SUM_W'(f_sel);
      sp <= sp + SUM_W'(p_sel);
      if (ch_bad) begin
        ok <= 1'b0;
      end
    end
    if (cmd.div_go) begin
      div_neg <= tmp[W-1];
    end
    if (mul_done) begin
      case (cmd.mul_sel)
        tpf_pkg::MS_DFDP:  num <= num + mul_p;
        tpf_pkg::MS_DFDF:  den <= den + mul_p;
        tpf_pkg::MS_NUMK:  tmp <= mul_p;
        tpf_pkg::MS_DENSP: tmp <= mul_p;
        tpf_pkg::MS_NUMSF: tmp <= tmp - mul_p;
        tpf_pkg::MS_DENN:  dvs <= mul_p;
        default:           tmp <= tmp;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/tone_phase_line_fit_test.sv
// Self-checking testbench for tone_phase_line_fit: random frames of channel samples,
// a line-fit predictor in exact wide arithmetic, and register writes between phases.
// Depends on tpf_pkg and the tone_phase_line_fit RTL only.
`timescale 1ns / 1ps

module tone_phase_line_fit_test;

  typedef struct {
    logic        err;
    logic [12:0] cc;
    logic [11:0] ch;
    logic [31:0] ph;
    logic        last;
  } sample_t;

  typedef struct {
    logic [47:0] tau;
    logic [47:0] theta;
    logic        ok;
    logic [31:0] good;
    logic [31:0] bad;
  } fit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [tpf_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tpf_pkg::M_TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tpf_pkg::ADDR_W-1:0] paddr = '0;
  logic [tpf_pkg::DATA_W-1:0] pwdata = '0;
  logic [tpf_pkg::DATA_W-1:0] prdata;
  logic pready;

  tone_phase_line_fit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  sample_t sample_q[$];
  fit_t    fit_q[$];
  int      samples_queued = 0;
  int      samples_taken = 0;
  int      fits_seen = 0;
  int      errors = 0;
  int      idle_cycles = 0;
  int      s_gap = 0;
  int      m_gap = 0;
  bit      s_took = 1'b0;
  bit      calm = 1'b0;

  logic        bypass_m = 1'b0;
  logic [2:0]  tone_cnt_m = 3'd2;
  logic [43:0] tone_w_m[4] = '{default: '0};
  logic [31:0] phase_m[4] = '{default: '0};
  logic [47:0] tau_m = '0;
  logic [47:0] theta_m = '0;
  logic        ok_m = 1'b0;
  logic [31:0] good_m = '0;
  logic [31:0] bad_m = '0;

  function automatic logic [47:0] round_sat48(logic signed [191:0] num,
                                               logic signed [191:0] den);
    logic signed [191:0] mag;
    logic signed [191:0] q;
    logic                neg;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = mag <<< 16;
    q = (mag + (den >>> 1)) / den;
    if (neg && q > 192'sd140737488355328) q = 192'sd140737488355328;
    if (!neg && q > 192'sd140737488355327) q = 192'sd140737488355327;
    if (neg) q = -q;
    return q[47:0];
  endfunction

  task automatic fit_line(input logic [12:0] cc);
    logic signed [191:0] f[4];
    logic signed [191:0] p[4];
    logic signed [191:0] sf, sp, num, den, df, dp, n;
    logic signed [31:0]  tmp;
    int                  cnt;
    bit                  ok;
    cnt = tone_cnt_m < 2 ? 2 : (tone_cnt_m > 4 ? 4 : tone_cnt_m);
    n = cnt;
    ok = 1'b1;
    sf = 0; sp = 0; num = 0; den = 0;
    for (int i = 0; i < cnt; i++) begin
      if ({1'b0, tone_w_m[i][43:32]} >= cc) ok = 1'b0;
      tmp = tone_w_m[i][31:0];
      f[i] = tmp;
      tmp = phase_m[i];
      p[i] = tmp;
      sf += f[i];
      sp += p[i];
    end
    if (ok) begin
      for (int i = 0; i < cnt; i++) begin
        df = n * f[i] - sf;
        dp = n * p[i] - sp;
        num += df * dp;
        den += df * df;
      end
    end
    if (!ok || den == 0) begin
      tau_m = '0;
      theta_m = '0;
      ok_m = 1'b0;
    end else begin
      tau_m = round_sat48(num * 192'sd683565276, den);
      theta_m = round_sat48(sp * den - num * sf, den * n);
      ok_m = 1'b1;
    end
  endtask

  task automatic predict_sample(input sample_t s);
    fit_t r;
    if (!bypass_m) begin
      for (int i = 0; i < 4; i++)
        if (tone_w_m[i][43:32] == s.ch) phase_m[i] = s.ph;
      if (s.last) begin
        if (s.err) bad_m++;
        else begin
          good_m++;
          fit_line(s.cc);
        end
      end
    end
    if (s.last) begin
      r = '{tau_m, theta_m, ok_m, good_m, bad_m};
      fit_q.insert(fit_q.size(), r);
    end
  endtask

  always @(posedge clk) begin
    s_took <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_sample('{s_tuser, s_tdata[12:0], s_tdata[24:13], s_tdata[56:25], s_tlast});
      samples_taken++;
    end
    if (!rst && m_tvalid && m_tready) begin
      fits_seen++;
      if (fit_q.size() == 0) begin
        $error("result with no frame waiting: %h", m_tdata);
        errors++;
      end else begin
        fit_t e;
        e = fit_q.pop_front();
        if (m_tdata[47:0] !== e.tau) begin
          $error("tau expected %h actual %h", e.tau, m_tdata[47:0]); errors++;
        end
        if (m_tdata[95:48] !== e.theta) begin
          $error("theta expected %h actual %h", e.theta, m_tdata[95:48]); errors++;
        end
        if (m_tuser !== e.ok) begin
          $error("fit_valid expected %b actual %b", e.ok, m_tuser); errors++;
        end
        if (m_tdata[127:96] !== e.good) begin
          $error("good_frames expected %0d actual %0d", e.good, m_tdata[127:96]); errors++;
        end
        if (m_tdata[159:128] !== e.bad) begin
          $error("bad_frames expected %0d actual %0d", e.bad, m_tdata[159:128]); errors++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (s_gap > 0) begin
        s_gap <= s_gap - 1;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        if (!calm && $urandom_range(0, 15) == 0) begin
          s_gap <= $urandom_range(0, 8);
          s_tvalid <= 1'b0;
        end else begin
          sample_t s;
          s = sample_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {7'b0, s.ph, s.ch, s.cc};
          s_tuser <= s.err;
          s_tlast <= s.last;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (m_gap > 0) begin
      m_gap <= m_gap - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      m_gap <= $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(input tpf_pkg::reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= tpf_pkg::ADDR_W'(8 * int'(idx)); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tpf_pkg::REG_BYPASS:     bypass_m = value[0];
      tpf_pkg::REG_TONE_COUNT: tone_cnt_m = value[2:0];
      tpf_pkg::REG_TONE_0:     tone_w_m[0] = value[43:0];
      tpf_pkg::REG_TONE_1:     tone_w_m[1] = value[43:0];
      tpf_pkg::REG_TONE_2:     tone_w_m[2] = value[43:0];
      tpf_pkg::REG_TONE_3:     tone_w_m[3] = value[43:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (samples_taken != samples_queued || fit_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic add_sample(input logic err, input logic [12:0] cc, input logic [11:0] ch,
                            input logic [31:0] ph, input logic last);
    sample_t s;
    s = '{err, cc, ch, ph, last};
    sample_q.insert(sample_q.size(), s);
    samples_queued++;
  endtask

  function automatic logic [31:0] pick_phase();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_frame(input int len, input logic err, input logic [12:0] cc);
    logic [11:0] ch;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 7) ch = tone_w_m[$urandom_range(0, 3)][43:32];
      else ch = 12'($urandom);
      add_sample(i == len - 1 ? err : logic'($urandom_range(0, 1)),
                 13'($urandom_range(0, 4096)), ch, pick_phase(), i == len - 1);
    end
    sample_q[$].cc = cc;
  endtask

  function automatic logic [12:0] pick_count();
    int top;
    int c;
    top = 0;
    for (int i = 0; i < 4; i++) if (tone_w_m[i][43:32] > top) top = tone_w_m[i][43:32];
    if ($urandom_range(0, 3) != 0) begin
      c = top + 1 + int'($urandom_range(0, 40));
      return 13'(c > 4096 ? 4096 : c);
    end
    return 13'($urandom_range(0, 4096));
  endfunction

  task automatic random_config();
    logic [31:0] fq;
    write_reg(tpf_pkg::REG_BYPASS, 64'($urandom_range(0, 5) == 0));
    write_reg(tpf_pkg::REG_TONE_COUNT, 64'($urandom_range(0, 7)));
    fq = $urandom;
    for (int i = 0; i < 4; i++) begin
      logic [11:0] ch;
      ch = $urandom_range(0, 1) ? 12'($urandom_range(0, 31)) : 12'($urandom);
      if ($urandom_range(0, 5) != 0) fq = $urandom_range(0, 2) == 0 ? 32'($urandom_range(0, 65535))
                                                                    : 32'($urandom);
      write_reg(tpf_pkg::reg_idx_t'(3'(int'(tpf_pkg::REG_TONE_0) + i)), {20'b0, ch, fq});
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset tones share channel 0 and frequency 0, so the variance is zero.
    push_frame(3, 1'b0, 13'd4096);
    push_frame(1, 1'b0, 13'd0);
    wait_drained();

    write_reg(tpf_pkg::REG_TONE_0, {20'b0, 12'd0, 32'h8000_0000});
    write_reg(tpf_pkg::REG_TONE_1, {20'b0, 12'd4095, 32'h7FFF_FFFF});
    write_reg(tpf_pkg::REG_TONE_2, 64'hFFF_FFFF_FFFF);
    write_reg(tpf_pkg::REG_TONE_3, {20'b0, 12'd7, 32'h0001_0000});
    write_reg(tpf_pkg::REG_TONE_COUNT, 64'd2);
    add_sample(1'b0, 13'd4096, 12'd0, 32'h7FFF_FFFF, 1'b0);
    add_sample(1'b0, 13'd4096, 12'd4095, 32'h8000_0000, 1'b1);
    add_sample(1'b0, 13'd4095, 12'd3, 32'h0, 1'b1);
    add_sample(1'b1, 13'd0, 12'd4095, 32'h7FFF_FFFF, 1'b1);
    add_sample(1'b0, 13'd4096, 12'd0, 32'h8000_0000, 1'b1);
    wait_drained();
    write_reg(tpf_pkg::REG_TONE_COUNT, 64'd7);
    push_frame(4, 1'b0, 13'd4096);
    wait_drained();
    write_reg(tpf_pkg::REG_TONE_COUNT, 64'd0);
    push_frame(3, 1'b0, 13'd4096);
    wait_drained();
    write_reg(tpf_pkg::REG_BYPASS, 64'd1);
    push_frame(3, 1'b0, 13'd4096);
    push_frame(2, 1'b1, 13'd4096);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      int goal;
      random_config();
      if (ph == 7) begin
        write_reg(tpf_pkg::REG_BYPASS, 64'd0);
        calm = 1'b1;
      end
      goal = samples_queued + 165;
      while (samples_queued < goal)
        push_frame($urandom_range(1, 12), $urandom_range(0, 7) == 0, pick_count());
      wait_drained();
    end

    $display("Checked %0d frame results from %0d samples over directed tone cases",
             fits_seen, samples_taken);
    $display("and eight random register settings, with stalls on both sides.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
